[rtl/dfr_pkg.sv]
// Package for the preamble frame deframer.
// Holds the phase codes, the preamble constant and the result struct.
// No dependencies.
`default_nettype none

package dfr_pkg;

  localparam logic [7:0] PreambleByte = 8'h55;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [2:0] PhWait   = 3'd0;
  localparam logic [2:0] PhType   = 3'd1;
  localparam logic [2:0] PhSender = 3'd2;
  localparam logic [2:0] PhLen    = 3'd3;
  localparam logic [2:0] PhMsg    = 3'd4;
  localparam logic [2:0] PhCrc    = 3'd5;

  localparam logic KindData     = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  typedef struct packed {
    logic        emit;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_type;
    logic [15:0] frame_sender;
    logic [7:0]  frame_length;
    logic        crc_ok;
  } result_t;

endpackage

`default_nettype wire

[rtl/dfr_crc16.sv]
// Byte-wide CRC-16-CCITT update, MSB first, not reflected.
// Uses the polynomial constant from dfr_pkg.
`default_nettype none

module dfr_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ dfr_pkg::CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

[rtl/dfr_parse.sv]
// Frame phase tracking, header capture and CRC accumulation.
// Depends on dfr_pkg and dfr_crc16; the result for the current byte is combinational.
`default_nettype none

module dfr_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output dfr_pkg::result_t  res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] type_q, type_d;
  logic [15:0] sender_q, sender_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] crc_next;
  logic [7:0]  count_inc;

  dfr_crc16 u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    type_d   = type_q;
    sender_d = sender_q;
    length_d = length_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;

    res_o.emit         = 1'b0;
    res_o.kind         = dfr_pkg::KindData;
    res_o.data_byte    = 8'h00;
    res_o.frame_type   = type_q;
    res_o.frame_sender = sender_q;
    res_o.frame_length = length_q;
    res_o.crc_ok       = 1'b0;

    case (phase_q)
      dfr_pkg::PhWait: begin
        if (byte_i == dfr_pkg::PreambleByte) begin
          count_d  = 8'd0;
          crc_d    = 16'h0000;
          rx_crc_d = 16'h0000;
          phase_d  = dfr_pkg::PhType;
        end
      end
      dfr_pkg::PhType: begin
        crc_d = crc_next;
        if (count_q == 8'd0) begin
          type_d  = {type_q[15:8], byte_i};
          count_d = 8'd1;
        end else begin
          type_d  = {byte_i, type_q[7:0]};
          count_d = 8'd0;
          phase_d = dfr_pkg::PhSender;
        end
      end
      dfr_pkg::PhSender: begin
        crc_d = crc_next;
        if (count_q == 8'd0) begin
          sender_d = {sender_q[15:8], byte_i};
          count_d  = 8'd1;
        end else begin
          sender_d = {byte_i, sender_q[7:0]};
          count_d  = 8'd0;
          phase_d  = dfr_pkg::PhLen;
        end
      end
      dfr_pkg::PhLen: begin
        crc_d    = crc_next;
        length_d = byte_i;
        count_d  = 8'd0;
        phase_d  = (byte_i == 8'd0) ? dfr_pkg::PhCrc : dfr_pkg::PhMsg;
      end
      dfr_pkg::PhMsg: begin
        crc_d   = crc_next;
        count_d = count_inc;
        if (count_inc >= length_q) begin
          count_d = 8'd0;
          phase_d = dfr_pkg::PhCrc;
        end
        res_o.emit      = 1'b1;
        res_o.kind      = dfr_pkg::KindData;
        res_o.data_byte = byte_i;
      end
      dfr_pkg::PhCrc: begin
        if (count_q == 8'd0) begin
          rx_crc_d = {rx_crc_q[15:8], byte_i};
          count_d  = 8'd1;
        end else begin
          rx_crc_d     = {byte_i, rx_crc_q[7:0]};
          count_d      = 8'd0;
          phase_d      = dfr_pkg::PhWait;
          res_o.emit   = 1'b1;
          res_o.kind   = dfr_pkg::KindFrameEnd;
          res_o.crc_ok = ({byte_i, rx_crc_q[7:0]} == crc_q);
        end
      end
      default: begin
        phase_d = dfr_pkg::PhWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dfr_pkg::PhWait;
      count_q  <= 8'd0;
      type_q   <= 16'h0000;
      sender_q <= 16'h0000;
      length_q <= 8'd0;
      crc_q    <= 16'h0000;
      rx_crc_q <= 16'h0000;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      type_q   <= type_d;
      sender_q <= sender_d;
      length_q <= length_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/preamble_frame_deframer_crc16.sv]
// Top level of the preamble frame deframer with CRC-16-CCITT check.
// Depends on dfr_pkg and dfr_parse; holds the input and result registers.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_byte_i) takes one received
//   byte per transfer. The block hunts for the preamble byte 0x55, collects
//   type, sender and length, forwards each payload byte as a result and ends
//   each frame with a frame-end result that carries the header fields and
//   the CRC verdict. Header, preamble and first CRC bytes give no result.
//   The output channel (out_valid_o, out_stall_i) carries one result per
//   transfer in kind_o, data_byte_o, frame_type_o, frame_sender_o,
//   frame_length_o and crc_ok_o.
//   Result valid rises when the parse logic takes the byte from the input
//   register and fills the result register.
//   Throughput is one byte per cycle while out_stall_i is low; the byte-wide
//   CRC update and the phase logic between the two registers set that figure.
//   Reset clears both valid flags and returns the parser to preamble hunting.
//   While the receiver stalls a held result, the input register keeps its
//   byte and in_stall_o rises once that register is full.
`default_nettype none

module preamble_frame_deframer_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] frame_type_o,
  output logic [15:0] frame_sender_o,
  output logic [7:0]  frame_length_o,
  output logic        crc_ok_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  dfr_pkg::result_t out_q;
  dfr_pkg::result_t res;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  dfr_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign data_byte_o    = out_q.data_byte;
  assign frame_type_o   = out_q.frame_type;
  assign frame_sender_o = out_q.frame_sender;
  assign frame_length_o = out_q.frame_length;
  assign crc_ok_o       = out_q.crc_ok;

`ifndef NO_ASSERTIONS
  a_stall_only_on_full_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i)
  ) else $error("Input stalled while the result register could take a transfer.");

  a_silent_byte_no_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && !res.emit) |=> !out_valid_q
  ) else $error("A byte without result left a result valid.");

  a_frame_end_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_o == dfr_pkg::KindFrameEnd) |-> (data_byte_o == 8'h00)
  ) else $error("Frame-end result carries a nonzero data byte.");

  a_data_no_verdict: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_o == dfr_pkg::KindData) |-> !crc_ok_o
  ) else $error("Payload result carries a CRC verdict.");
`endif

endmodule

`default_nettype wire
